// ===== rtl/core/skmm_pkg.sv =====
package skmm_pkg;

  localparam int MAX_RIGHT = 64;
  localparam int FRAC_BITS = 4;
  localparam int IDX_W     = 6;
  localparam int CNT_W     = 7;

  localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_RIGHT);
  localparam logic signed [14:0] FULL_TURN = 15'(360 << FRAC_BITS);

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_LOAD  = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  localparam logic [2:0] CFG_Y_TOL     = 3'd0;
  localparam logic [2:0] CFG_ANGLE_TOL = 3'd1;
  localparam logic [2:0] CFG_SIZE_TOL  = 3'd2;
  localparam logic [2:0] CFG_DISP_MIN  = 3'd3;
  localparam logic [2:0] CFG_DISP_MAX  = 3'd4;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [12:0] angle;
    logic [11:0] size;
  } key_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             key_capture;
    logic             issue;
    logic [IDX_W-1:0] rd_addr;
    logic             rd_last;
  } cmd_t;

  typedef struct packed {
    logic adv;
    logic s1_valid;
  } sts_t;

endpackage

// ===== rtl/core/stereo_keypoint_match_mask_unit.sv =====
// Stereo keypoint match mask. Mode 1 requests load right keypoints into a 64-entry store,
// mode 0 empties it, and a mode 2 request tests one left keypoint against every stored
// entry in index order, giving one result (index, match, last) per entry and none when
// the store is empty. A query streams one result per cycle from the store read port
// while the output is not stalled, and it holds off new requests while it runs.
// Configuration writes are always ready and must only be issued while no query is in flight.
module stereo_keypoint_match_mask_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_mode,
  input  logic [15:0]                 in_key_x,
  input  logic [15:0]                 in_key_y,
  input  logic [12:0]                 in_key_angle,
  input  logic [11:0]                 in_key_size,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [skmm_pkg::IDX_W-1:0]  out_right_index,
  output logic                        out_match,
  output logic                        out_last,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [2:0]                  cfg_index,
  input  logic [16:0]                 cfg_data
);

  skmm_pkg::cmd_t cmd;
  skmm_pkg::sts_t sts;

  skmm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_mode  (in_mode),
    .sts      (sts),
    .cmd      (cmd)
  );

  skmm_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_key_x        (in_key_x),
    .in_key_y        (in_key_y),
    .in_key_angle    (in_key_angle),
    .in_key_size     (in_key_size),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_right_index (out_right_index),
    .out_match       (out_match),
    .out_last        (out_last),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

// ===== rtl/core/skmm_ctrl.sv =====
module skmm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_mode,
  input  skmm_pkg::sts_t      sts,
  output skmm_pkg::cmd_t      cmd
);

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t                         state_r, state_nxt;
  logic [skmm_pkg::CNT_W-1:0]     count_r, count_nxt;
  logic [skmm_pkg::IDX_W-1:0]     idx_r, idx_nxt;
  logic                           accept;
  logic                           is_last;

  assign in_stall = (state_r != ST_IDLE) || sts.s1_valid;
  assign accept   = in_valid && !in_stall;
  assign is_last  = ({1'b0, idx_r} == (count_r - skmm_pkg::CNT_W'(1)));

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    idx_nxt         = idx_r;
    cmd             = '0;
    cmd.wr_addr     = count_r[skmm_pkg::IDX_W-1:0];
    cmd.rd_addr     = idx_r;
    cmd.rd_last     = is_last;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_mode)
            skmm_pkg::MODE_CLEAR: count_nxt = '0;
            skmm_pkg::MODE_LOAD: begin
              if (count_r < skmm_pkg::MAX_COUNT) begin
                cmd.wr_en = 1'b1;
                count_nxt = count_r + skmm_pkg::CNT_W'(1);
              end
            end
            skmm_pkg::MODE_QUERY: begin
              if (count_r != '0) begin
                cmd.key_capture = 1'b1;
                idx_nxt         = '0;
                state_nxt       = ST_RUN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        if (sts.adv) begin
          idx_nxt = idx_r + skmm_pkg::IDX_W'(1);
          if (is_last) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
    end
  end

  a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> count_r != '0 && {1'b0, idx_r} < count_r)
    else $error("query index outside stored range");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= skmm_pkg::MAX_COUNT)
    else $error("store count above capacity");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue && cmd.rd_last && sts.adv |=> state_r == ST_IDLE)
    else $error("query did not end after last request");

  a_no_write_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> state_r == ST_IDLE && !cmd.issue)
    else $error("store write during query");

endmodule

// ===== rtl/core/skmm_dp.sv =====
module skmm_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [15:0]                  in_key_x,
  input  logic [15:0]                  in_key_y,
  input  logic [12:0]                  in_key_angle,
  input  logic [11:0]                  in_key_size,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [2:0]                   cfg_index,
  input  logic [16:0]                  cfg_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [skmm_pkg::IDX_W-1:0]   out_right_index,
  output logic                         out_match,
  output logic                         out_last,
  input  skmm_pkg::cmd_t               cmd,
  output skmm_pkg::sts_t               sts
);

  skmm_pkg::key_t mem [skmm_pkg::MAX_RIGHT];
  skmm_pkg::key_t rd_data_r;
  skmm_pkg::key_t key_r;
  skmm_pkg::key_t wdata;

  logic [15:0]        y_tol_r;
  logic [12:0]        angle_tol_r;
  logic [11:0]        size_tol_r;
  logic signed [16:0] disp_min_r;
  logic signed [16:0] disp_max_r;

  logic                       s1_valid_r;
  logic [skmm_pkg::IDX_W-1:0] s1_idx_r;
  logic                       s1_last_r;
  logic                       out_valid_r;
  logic [skmm_pkg::IDX_W-1:0] out_idx_r;
  logic                       out_match_r;
  logic                       out_last_r;

  logic                adv;
  logic [15:0]         dy;
  logic [12:0]         da;
  logic [11:0]         ds;
  logic signed [14:0]  wrap;
  logic signed [16:0]  disp;
  logic                y_ok, a_ok, s_ok, d_ok, match;

  assign cfg_ready = 1'b1;
  assign adv       = !out_valid_r || !out_stall;
  assign sts.adv      = adv;
  assign sts.s1_valid = s1_valid_r;

  assign wdata.x     = in_key_x;
  assign wdata.y     = in_key_y;
  assign wdata.angle = in_key_angle;
  assign wdata.size  = in_key_size;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[cmd.wr_addr] <= wdata;
    if (adv) rd_data_r <= mem[cmd.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.key_capture) key_r <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_tol_r     <= 16'd32;
      angle_tol_r <= 13'd160;
      size_tol_r  <= 12'd80;
      disp_min_r  <= 17'sd0;
      disp_max_r  <= 17'sd4096;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        skmm_pkg::CFG_Y_TOL:     y_tol_r     <= cfg_data[15:0];
        skmm_pkg::CFG_ANGLE_TOL: angle_tol_r <= cfg_data[12:0];
        skmm_pkg::CFG_SIZE_TOL:  size_tol_r  <= cfg_data[11:0];
        skmm_pkg::CFG_DISP_MIN:  disp_min_r  <= signed'(cfg_data);
        skmm_pkg::CFG_DISP_MAX:  disp_max_r  <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  // pair test against the registered store entry
  always_comb begin
    dy   = (key_r.y >= rd_data_r.y) ? key_r.y - rd_data_r.y : rd_data_r.y - key_r.y;
    da   = (key_r.angle >= rd_data_r.angle) ? key_r.angle - rd_data_r.angle
                                            : rd_data_r.angle - key_r.angle;
    ds   = (key_r.size >= rd_data_r.size) ? key_r.size - rd_data_r.size
                                          : rd_data_r.size - key_r.size;
    wrap = skmm_pkg::FULL_TURN - signed'({2'b00, da});
    disp = signed'({1'b0, key_r.x}) - signed'({1'b0, rd_data_r.x});
    y_ok = dy <= y_tol_r;
    a_ok = (da <= angle_tol_r) || (wrap <= signed'({2'b00, angle_tol_r}));
    s_ok = ds <= size_tol_r;
    d_ok = (disp >= disp_min_r) && (disp <= disp_max_r);
    match = y_ok && a_ok && s_ok && d_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= cmd.issue;
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_idx_r    <= cmd.rd_addr;
      s1_last_r   <= cmd.rd_last;
      out_idx_r   <= s1_idx_r;
      out_match_r <= match;
      out_last_r  <= s1_last_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_right_index = out_idx_r;
  assign out_match       = out_match_r;
  assign out_last        = out_last_r;

endmodule
